### hdl/depth_pixel_to_world_point_assert.svh
// Assertion macros for the checker file of the depth back-projection block.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH

// Clocked assertion, switched off while reset is low.
`define DPW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define DPW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### hdl/dpw_pkg.sv
`default_nettype none

package dpw_pkg;

    // Image bounds
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    // Port widths
    localparam int COORD_W    = 10;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int WORLD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register field widths
    localparam int PP_HALF_W  = 16;
    localparam int PP_W       = 2 * PP_HALF_W;
    localparam int INVF_W     = 24;
    localparam int INVF_REG_W = 2 * INVF_W;
    localparam int DU_W       = 24;
    localparam int ROT_W      = 18;
    localparam int ROT_ROW_W  = 3 * ROT_W;
    localparam int TR_W       = 21;
    localparam int TR_REG_W   = 3 * TR_W;

    // Camera-side datapath widths
    localparam int OFF_W        = COORD_W + 4 + 4;      // signed Q.4 offset
    localparam int MAG_W        = PP_HALF_W;            // offset magnitude
    localparam int Z24_W        = DEPTH_W + DU_W;       // depth in Q.24
    localparam int PROD_W       = MAG_W + INVF_W;       // offset * 1/f
    localparam int HALF_W       = 20;                   // partial product split
    localparam int PART_W       = 2 * HALF_W;
    localparam int MID_W        = PART_W + 1;
    localparam int CARRY_W      = MID_W + 1;
    localparam int CARRY_SHIFT  = 16;
    localparam int CARRY_KEEP_W = CARRY_W - CARRY_SHIFT;
    localparam int QSUM_W       = PART_W + 8 + 1;
    localparam int CAM_MAG_W    = 39;                   // |camera coord| < 2^39
    localparam int CAM_W        = CAM_MAG_W + 1;
    localparam int CAMZ_W       = Z24_W - 8;

    // World-side datapath widths
    localparam int PH_W   = ROT_W + HALF_W;
    localparam int PL_W   = ROT_W + HALF_W + 1;
    localparam int TERM_W = PH_W + HALF_W;
    localparam int SUM_W  = TERM_W + 2;
    localparam int Q_W    = SUM_W - 16;

    // Rounding constants
    localparam logic [MID_W-1:0]  LAT_RND   = MID_W'(64'h8_0000_0000);  // half of 2^36
    localparam logic [Z24_W:0]    CAMZ_RND  = (Z24_W + 1)'(128);
    localparam logic [HALF_W-1:0] WORLD_RND = 20'h08000;

    // Saturation limits
    localparam logic signed [WORLD_W-1:0] WORLD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORLD_W-1:0] WORLD_MIN = 32'sh8000_0000;

    // Pipeline stage numbers
    localparam int STG_IN     = 1;   // depth product, principal offsets
    localparam int STG_PROD   = 2;   // offset * inverse focal
    localparam int STG_PART   = 3;   // 20x20 partial products
    localparam int STG_MID    = 4;   // middle sum, rounding bias
    localparam int STG_CARRY  = 5;   // carry into upper bits
    localparam int STG_SAT    = 6;   // quotient and saturation
    localparam int STG_CAM    = 7;   // signed camera coordinate
    localparam int STG_ROT    = 8;   // rotation partial products
    localparam int STG_TERM   = 9;   // rotation terms
    localparam int STG_PAIR   = 10;  // pairwise sums
    localparam int STG_OUT    = 11;  // final sum, round, saturate
    localparam int NUM_STAGES = STG_OUT;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRINCIPAL   = 3'd0,
        REG_INV_FOCAL   = 3'd1,
        REG_DEPTH_UNIT  = 3'd2,
        REG_ROT_ROW0    = 3'd3,
        REG_ROT_ROW1    = 3'd4,
        REG_ROT_ROW2    = 3'd5,
        REG_TRANSLATION = 3'd6
    } cfg_index_t;

    // Register reset values
    localparam logic [PP_W-1:0]       PP_RESET   = 32'd265819224;
    localparam logic [INVF_REG_W-1:0] INVF_RESET = 48'd542340316805;
    localparam logic [DU_W-1:0]       DU_RESET   = 24'd16777;
    localparam logic [ROT_ROW_W-1:0]  ROT0_RESET = 54'd65536;
    localparam logic [ROT_ROW_W-1:0]  ROT1_RESET = 54'd17179869184;
    localparam logic [ROT_ROW_W-1:0]  ROT2_RESET = 54'd4503599627370496;
    localparam logic [TR_REG_W-1:0]   TR_RESET   = '0;

    // Per-stage load strobes handed to the datapath units
    typedef struct packed {
        logic [NUM_STAGES:1] load;
    } dpw_ctrl_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

endpackage

`default_nettype wire

### hdl/depth_pixel_to_world_point.sv
// Depth pixel to world point.
// Input channel (s_*): one beat per RGB-D pixel, column, row, raw depth and color.
// A beat with zero depth, or outside the image, is consumed and gives no result.
// Every other beat gives one result beat (m_*): the world point in signed Q16.16
// metres, saturated, plus the color passed through.
// Configuration channel (cfg_*): index and data, always ready; write only while
// no pixels are in flight. Unknown indexes are dropped.
// Throughput: one pixel per cycle while the output is not stalled, through an
// eleven-stage pipeline with one register stage per multiply or wide add.
// Reset: the pipeline empties and every configuration register returns to its
// default (identity rotation, zero translation, 1/1000 metre depth unit).
// Stall: with m_ready low the result holds; earlier stages keep filling empty
// slots, and s_ready drops only once every stage holds a pixel.
`default_nettype none

module depth_pixel_to_world_point (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // pixel input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [dpw_pkg::COORD_W-1:0]        s_column,
    input  wire logic [dpw_pkg::COORD_W-1:0]        s_row_index,
    input  wire logic [dpw_pkg::DEPTH_W-1:0]        s_raw_depth,
    input  wire logic [dpw_pkg::COLOR_W-1:0]        s_blue_in,
    input  wire logic [dpw_pkg::COLOR_W-1:0]        s_green_in,
    input  wire logic [dpw_pkg::COLOR_W-1:0]        s_red_in,
    // world point output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [dpw_pkg::WORLD_W-1:0]      m_world_x,
    output logic signed [dpw_pkg::WORLD_W-1:0]      m_world_y,
    output logic signed [dpw_pkg::WORLD_W-1:0]      m_world_z,
    output logic [dpw_pkg::COLOR_W-1:0]             m_red_out,
    output logic [dpw_pkg::COLOR_W-1:0]             m_green_out,
    output logic [dpw_pkg::COLOR_W-1:0]             m_blue_out,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NS = dpw_pkg::NUM_STAGES;

    // Configuration registers
    logic [dpw_pkg::PP_W-1:0]       principal_reg;
    logic [dpw_pkg::INVF_REG_W-1:0] inv_focal_reg;
    logic [dpw_pkg::DU_W-1:0]       depth_unit_reg;
    logic [dpw_pkg::ROT_ROW_W-1:0]  rot_row0_reg, rot_row1_reg, rot_row2_reg;
    logic [dpw_pkg::TR_REG_W-1:0]   translation_reg;

    // Pipeline control
    logic [NS:1]         vld_reg, vld_next;
    logic [NS:1]         stage_en;
    logic                keep;
    dpw_pkg::dpw_ctrl_t  ctrl;

    // Stage one payload
    logic [dpw_pkg::Z24_W-1:0]       z24_reg;
    logic [dpw_pkg::MAG_W-1:0]       magx_reg, magy_reg;
    logic                            negx_reg, negy_reg;
    logic signed [dpw_pkg::OFF_W-1:0] offx_next, offy_next;
    logic [dpw_pkg::MAG_W-1:0]       magx_next, magy_next;

    // Camera Z and color delay lines
    logic [dpw_pkg::CAMZ_W-1:0]      camz_reg [dpw_pkg::STG_PROD:dpw_pkg::STG_CAM];
    logic [dpw_pkg::Z24_W:0]         camz_sum;
    dpw_pkg::color_t                 color_reg [1:NS];

    logic signed [dpw_pkg::CAM_W-1:0] cam_x, cam_y, cam_z;

    assign cfg_ready = 1'b1;

    // Register writes, masked to each register's width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            principal_reg   <= dpw_pkg::PP_RESET;
            inv_focal_reg   <= dpw_pkg::INVF_RESET;
            depth_unit_reg  <= dpw_pkg::DU_RESET;
            rot_row0_reg    <= dpw_pkg::ROT0_RESET;
            rot_row1_reg    <= dpw_pkg::ROT1_RESET;
            rot_row2_reg    <= dpw_pkg::ROT2_RESET;
            translation_reg <= dpw_pkg::TR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (dpw_pkg::cfg_index_t'(cfg_index))
                dpw_pkg::REG_PRINCIPAL:   principal_reg   <= cfg_data[dpw_pkg::PP_W-1:0];
                dpw_pkg::REG_INV_FOCAL:   inv_focal_reg   <= cfg_data[dpw_pkg::INVF_REG_W-1:0];
                dpw_pkg::REG_DEPTH_UNIT:  depth_unit_reg  <= cfg_data[dpw_pkg::DU_W-1:0];
                dpw_pkg::REG_ROT_ROW0:    rot_row0_reg    <= cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                dpw_pkg::REG_ROT_ROW1:    rot_row1_reg    <= cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                dpw_pkg::REG_ROT_ROW2:    rot_row2_reg    <= cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                dpw_pkg::REG_TRANSLATION: translation_reg <= cfg_data[dpw_pkg::TR_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    always_comb begin
        stage_en[NS] = !vld_reg[NS] || m_ready;
        for (int i = NS - 1; i >= 1; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i + 1];
        end
        ctrl.load = stage_en;
    end

    assign s_ready = stage_en[1];

    // Zero depth and out-of-image pixels are consumed without a result
    assign keep = s_valid && (s_raw_depth != '0)
               && (int'(s_column) < dpw_pkg::MAX_COLUMNS)
               && (int'(s_row_index) < dpw_pkg::MAX_ROWS);

    always_comb begin
        vld_next[1] = stage_en[1] ? keep : vld_reg[1];
        for (int i = 2; i <= NS; i++) begin
            vld_next[i] = stage_en[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Principal point offsets in signed Q.4 and their magnitudes
    always_comb begin
        offx_next = $signed({4'h0, s_column, 4'h0})
                  - $signed({2'b00, principal_reg[dpw_pkg::PP_HALF_W-1:0]});
        offy_next = $signed({4'h0, s_row_index, 4'h0})
                  - $signed({2'b00, principal_reg[dpw_pkg::PP_W-1:dpw_pkg::PP_HALF_W]});
        magx_next = offx_next[dpw_pkg::OFF_W-1] ? dpw_pkg::MAG_W'(-offx_next)
                                                : offx_next[dpw_pkg::MAG_W-1:0];
        magy_next = offy_next[dpw_pkg::OFF_W-1] ? dpw_pkg::MAG_W'(-offy_next)
                                                : offy_next[dpw_pkg::MAG_W-1:0];
        camz_sum  = dpw_pkg::Z24_W'(0) + {1'b0, z24_reg} + dpw_pkg::CAMZ_RND;
    end

    // Input stage, camera Z rounding and the delay lines
    always_ff @(posedge aclk) begin
        if (stage_en[dpw_pkg::STG_IN]) begin
            z24_reg  <= dpw_pkg::Z24_W'(s_raw_depth) * dpw_pkg::Z24_W'(depth_unit_reg);
            magx_reg <= magx_next;
            negx_reg <= offx_next[dpw_pkg::OFF_W-1];
            magy_reg <= magy_next;
            negy_reg <= offy_next[dpw_pkg::OFF_W-1];
            color_reg[1] <= '{red: s_red_in, green: s_green_in, blue: s_blue_in};
        end
        if (stage_en[dpw_pkg::STG_PROD]) begin
            camz_reg[dpw_pkg::STG_PROD] <= camz_sum[dpw_pkg::Z24_W-1:8];
        end
        for (int i = dpw_pkg::STG_PROD + 1; i <= dpw_pkg::STG_CAM; i++) begin
            if (stage_en[i]) begin
                camz_reg[i] <= camz_reg[i - 1];
            end
        end
        for (int i = 2; i <= NS; i++) begin
            if (stage_en[i]) begin
                color_reg[i] <= color_reg[i - 1];
            end
        end
    end

    // Camera X and Y
    dpw_lateral u_lateral_x (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .mag_in  (magx_reg),
        .neg_in  (negx_reg),
        .invf    (inv_focal_reg[dpw_pkg::INVF_W-1:0]),
        .z24_in  (z24_reg),
        .cam_out (cam_x)
    );

    dpw_lateral u_lateral_y (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .mag_in  (magy_reg),
        .neg_in  (negy_reg),
        .invf    (inv_focal_reg[dpw_pkg::INVF_REG_W-1:dpw_pkg::INVF_W]),
        .z24_in  (z24_reg),
        .cam_out (cam_y)
    );

    assign cam_z = $signed({{(dpw_pkg::CAM_W - dpw_pkg::CAMZ_W){1'b0}},
                            camz_reg[dpw_pkg::STG_CAM]});

    // Rigid transform, one unit per world axis
    dpw_world_axis u_world_x (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_row0_reg),
        .trans   (translation_reg[dpw_pkg::TR_W-1:0]),
        .cam_x   (cam_x),
        .cam_y   (cam_y),
        .cam_z   (cam_z),
        .world   (m_world_x)
    );

    dpw_world_axis u_world_y (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_row1_reg),
        .trans   (translation_reg[2*dpw_pkg::TR_W-1:dpw_pkg::TR_W]),
        .cam_x   (cam_x),
        .cam_y   (cam_y),
        .cam_z   (cam_z),
        .world   (m_world_y)
    );

    dpw_world_axis u_world_z (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rot_row (rot_row2_reg),
        .trans   (translation_reg[dpw_pkg::TR_REG_W-1:2*dpw_pkg::TR_W]),
        .cam_x   (cam_x),
        .cam_y   (cam_y),
        .cam_z   (cam_z),
        .world   (m_world_z)
    );

    assign m_valid     = vld_reg[NS];
    assign m_red_out   = color_reg[NS].red;
    assign m_green_out = color_reg[NS].green;
    assign m_blue_out  = color_reg[NS].blue;

endmodule

`default_nettype wire

### hdl/dpw_lateral.sv
`default_nettype none

// Lateral camera coordinate: round(|offset| * invf * z24 / 2^36), capped, signed.
module dpw_lateral (
    input  wire logic                                aclk,
    input  wire dpw_pkg::dpw_ctrl_t                  ctrl,
    input  wire logic [dpw_pkg::MAG_W-1:0]           mag_in,
    input  wire logic                                neg_in,
    input  wire logic [dpw_pkg::INVF_W-1:0]          invf,
    input  wire logic [dpw_pkg::Z24_W-1:0]           z24_in,
    output logic signed [dpw_pkg::CAM_W-1:0]         cam_out
);

    localparam int HW = dpw_pkg::HALF_W;

    logic [dpw_pkg::PROD_W-1:0]       prod_reg;
    logic [dpw_pkg::Z24_W-1:0]        z_reg;
    logic                             neg2_reg;
    logic [dpw_pkg::PART_W-1:0]       hh3_reg, hl3_reg, lh3_reg, ll3_reg;
    logic                             neg3_reg;
    logic [dpw_pkg::MID_W-1:0]        mid_reg, low_reg;
    logic [dpw_pkg::PART_W-1:0]       hh4_reg;
    logic                             neg4_reg;
    logic [dpw_pkg::CARRY_KEEP_W-1:0] carry_reg;
    logic [dpw_pkg::PART_W-1:0]       hh5_reg;
    logic                             neg5_reg;
    logic [dpw_pkg::CAM_MAG_W-1:0]    mag6_reg;
    logic                             neg6_reg;
    logic signed [dpw_pkg::CAM_W-1:0] cam_reg;

    logic [dpw_pkg::CARRY_W-1:0]      carry_next;
    logic [dpw_pkg::QSUM_W-1:0]       qsum_next;
    logic [dpw_pkg::CAM_MAG_W-1:0]    mag6_next;
    logic signed [dpw_pkg::CAM_W-1:0] cam_next;

    // Carry the middle sum into bit 36 and above
    always_comb begin
        carry_next = dpw_pkg::CARRY_W'(mid_reg)
                   + dpw_pkg::CARRY_W'(low_reg[dpw_pkg::MID_W-1:HW]);
        // upper partial sits at bit 40, i.e. bit 4 of the Q.16 result
        qsum_next  = dpw_pkg::QSUM_W'({hh5_reg, 4'h0}) + dpw_pkg::QSUM_W'(carry_reg);
        // anything above bit 38 means the magnitude is past the camera range
        if (|qsum_next[dpw_pkg::QSUM_W-1:dpw_pkg::CAM_MAG_W]) begin
            mag6_next = '1;
        end else begin
            mag6_next = qsum_next[dpw_pkg::CAM_MAG_W-1:0];
        end
        if (neg6_reg) begin
            cam_next = -$signed({1'b0, mag6_reg});
        end else begin
            cam_next = $signed({1'b0, mag6_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[dpw_pkg::STG_PROD]) begin
            prod_reg <= dpw_pkg::PROD_W'(mag_in) * dpw_pkg::PROD_W'(invf);
            z_reg    <= z24_in;
            neg2_reg <= neg_in;
        end
        // four 20x20 partial products of the 40x40 product
        if (ctrl.load[dpw_pkg::STG_PART]) begin
            hh3_reg  <= dpw_pkg::PART_W'(prod_reg[2*HW-1:HW]) * dpw_pkg::PART_W'(z_reg[2*HW-1:HW]);
            hl3_reg  <= dpw_pkg::PART_W'(prod_reg[2*HW-1:HW]) * dpw_pkg::PART_W'(z_reg[HW-1:0]);
            lh3_reg  <= dpw_pkg::PART_W'(prod_reg[HW-1:0]) * dpw_pkg::PART_W'(z_reg[2*HW-1:HW]);
            ll3_reg  <= dpw_pkg::PART_W'(prod_reg[HW-1:0]) * dpw_pkg::PART_W'(z_reg[HW-1:0]);
            neg3_reg <= neg2_reg;
        end
        if (ctrl.load[dpw_pkg::STG_MID]) begin
            mid_reg  <= dpw_pkg::MID_W'(hl3_reg) + dpw_pkg::MID_W'(lh3_reg);
            low_reg  <= dpw_pkg::MID_W'(ll3_reg) + dpw_pkg::LAT_RND;
            hh4_reg  <= hh3_reg;
            neg4_reg <= neg3_reg;
        end
        if (ctrl.load[dpw_pkg::STG_CARRY]) begin
            carry_reg <= carry_next[dpw_pkg::CARRY_W-1:dpw_pkg::CARRY_SHIFT];
            hh5_reg   <= hh4_reg;
            neg5_reg  <= neg4_reg;
        end
        if (ctrl.load[dpw_pkg::STG_SAT]) begin
            mag6_reg <= mag6_next;
            neg6_reg <= neg5_reg;
        end
        if (ctrl.load[dpw_pkg::STG_CAM]) begin
            cam_reg <= cam_next;
        end
    end

    assign cam_out = cam_reg;

endmodule

`default_nettype wire

### hdl/dpw_world_axis.sv
`default_nettype none

// One world axis: R row . camera point + t, rounded to Q16.16 and saturated.
module dpw_world_axis (
    input  wire logic                                aclk,
    input  wire dpw_pkg::dpw_ctrl_t                  ctrl,
    input  wire logic [dpw_pkg::ROT_ROW_W-1:0]       rot_row,
    input  wire logic [dpw_pkg::TR_W-1:0]            trans,
    input  wire logic signed [dpw_pkg::CAM_W-1:0]    cam_x,
    input  wire logic signed [dpw_pkg::CAM_W-1:0]    cam_y,
    input  wire logic signed [dpw_pkg::CAM_W-1:0]    cam_z,
    output logic signed [dpw_pkg::WORLD_W-1:0]       world
);

    localparam int HW = dpw_pkg::HALF_W;

    logic signed [dpw_pkg::ROT_W-1:0]   rot [3];
    logic signed [dpw_pkg::CAM_W-1:0]   cam [3];
    logic signed [dpw_pkg::PH_W-1:0]    ph_reg [3];
    logic signed [dpw_pkg::PL_W-1:0]    pl_reg [3];
    logic signed [dpw_pkg::TERM_W-1:0]  term_reg [3];
    logic signed [dpw_pkg::SUM_W-1:0]   pair_reg, rest_reg;
    logic signed [dpw_pkg::WORLD_W-1:0] world_reg;

    logic signed [dpw_pkg::SUM_W-1:0]   sum_next;
    logic [dpw_pkg::Q_W-1:0]            q_next;
    logic signed [dpw_pkg::WORLD_W-1:0] world_next;

    // Unpack the rotation row, lowest entry first
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rot[k] = $signed(rot_row[k*dpw_pkg::ROT_W +: dpw_pkg::ROT_W]);
        end
        cam[0] = cam_x;
        cam[1] = cam_y;
        cam[2] = cam_z;
    end

    // Final sum, arithmetic shift to Q.16, saturate to 32 bits
    always_comb begin
        sum_next = pair_reg + rest_reg;
        q_next   = sum_next[dpw_pkg::SUM_W-1:16];
        if (&q_next[dpw_pkg::Q_W-1:dpw_pkg::WORLD_W-1]
                || ~|q_next[dpw_pkg::Q_W-1:dpw_pkg::WORLD_W-1]) begin
            world_next = $signed(q_next[dpw_pkg::WORLD_W-1:0]);
        end else if (q_next[dpw_pkg::Q_W-1]) begin
            world_next = dpw_pkg::WORLD_MIN;
        end else begin
            world_next = dpw_pkg::WORLD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        // camera coordinate split in a signed upper and an unsigned lower half
        if (ctrl.load[dpw_pkg::STG_ROT]) begin
            for (int k = 0; k < 3; k++) begin
                ph_reg[k] <= dpw_pkg::PH_W'(rot[k])
                           * dpw_pkg::PH_W'($signed(cam[k][2*HW-1:HW]));
                pl_reg[k] <= dpw_pkg::PL_W'(rot[k])
                           * dpw_pkg::PL_W'($signed({1'b0, cam[k][HW-1:0]}));
            end
        end
        if (ctrl.load[dpw_pkg::STG_TERM]) begin
            for (int k = 0; k < 3; k++) begin
                term_reg[k] <= $signed({ph_reg[k], {HW{1'b0}}}) + dpw_pkg::TERM_W'(pl_reg[k]);
            end
        end
        // translation moves to Q.32 with the half-LSB rounding bias below it
        if (ctrl.load[dpw_pkg::STG_PAIR]) begin
            pair_reg <= dpw_pkg::SUM_W'(term_reg[0]) + dpw_pkg::SUM_W'(term_reg[1]);
            rest_reg <= dpw_pkg::SUM_W'(term_reg[2])
                      + dpw_pkg::SUM_W'($signed({trans, dpw_pkg::WORLD_RND}));
        end
        if (ctrl.load[dpw_pkg::STG_OUT]) begin
            world_reg <= world_next;
        end
    end

    assign world = world_reg;

endmodule

`default_nettype wire

### hdl/dpw_checker.sv
`default_nettype none

`include "depth_pixel_to_world_point_assert.svh"

module dpw_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic [dpw_pkg::COORD_W-1:0]        s_column,
    input wire logic [dpw_pkg::COORD_W-1:0]        s_row_index,
    input wire logic [dpw_pkg::DEPTH_W-1:0]        s_raw_depth,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [dpw_pkg::WORLD_W-1:0] m_world_x,
    input wire logic signed [dpw_pkg::WORLD_W-1:0] m_world_y,
    input wire logic signed [dpw_pkg::WORLD_W-1:0] m_world_z,
    input wire logic [dpw_pkg::COLOR_W-1:0]        m_red_out,
    input wire logic [dpw_pkg::COLOR_W-1:0]        m_green_out,
    input wire logic [dpw_pkg::COLOR_W-1:0]        m_blue_out,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready,
    input wire logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input wire logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NS = dpw_pkg::NUM_STAGES;

    logic [3*dpw_pkg::WORLD_W+3*dpw_pkg::COLOR_W-1:0] m_beat;
    logic            hit, flow_ok, cfg_beat;
    logic [NS-1:0]   hit_hist_reg;
    logic [NS-2:0]   flow_hist_reg;

    assign m_beat = {m_world_x, m_world_y, m_world_z, m_red_out, m_green_out, m_blue_out};

    // a pixel beat that must come out as a result
    assign hit = aresetn && s_valid && s_ready && (s_raw_depth != '0)
              && (int'(s_column) < dpw_pkg::MAX_COLUMNS)
              && (int'(s_row_index) < dpw_pkg::MAX_ROWS);
    assign flow_ok  = aresetn && m_ready;
    assign cfg_beat = cfg_valid && cfg_ready && (cfg_index != '0) && (cfg_data != '0);

    // History of result-producing beats and of stall-free cycles
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_hist_reg  <= '0;
            flow_hist_reg <= '0;
        end else begin
            hit_hist_reg  <= {hit_hist_reg[NS-2:0], hit};
            flow_hist_reg <= {flow_hist_reg[NS-3:0], flow_ok};
        end
    end

    `DPW_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

    `DPW_ASSERT(a_ready_when_draining, aclk, aresetn, (m_ready || !m_valid) |-> s_ready, "input stalled while output drains")

    `DPW_ASSERT(a_stall_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_beat), "stalled result beat changed")

    `DPW_ASSERT(a_latency, aclk, aresetn, hit_hist_reg[NS-1] && (&flow_hist_reg) && !cfg_beat |-> m_valid, "result missing eleven cycles after pixel")

endmodule

bind depth_pixel_to_world_point dpw_checker u_dpw_checker (.*);

`default_nettype wire

### bench/depth_pixel_to_world_point_checker.sv
`timescale 1ns / 1ps

module depth_pixel_to_world_point_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [dpw_pkg::COORD_W-1:0]        s_column,
    input  logic [dpw_pkg::COORD_W-1:0]        s_row_index,
    input  logic [dpw_pkg::DEPTH_W-1:0]        s_raw_depth,
    input  logic [dpw_pkg::COLOR_W-1:0]        s_blue_in,
    input  logic [dpw_pkg::COLOR_W-1:0]        s_green_in,
    input  logic [dpw_pkg::COLOR_W-1:0]        s_red_in,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [dpw_pkg::WORLD_W-1:0] m_world_x,
    input  logic signed [dpw_pkg::WORLD_W-1:0] m_world_y,
    input  logic signed [dpw_pkg::WORLD_W-1:0] m_world_z,
    input  logic [dpw_pkg::COLOR_W-1:0]        m_red_out,
    input  logic [dpw_pkg::COLOR_W-1:0]        m_green_out,
    input  logic [dpw_pkg::COLOR_W-1:0]        m_blue_out,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatch_count,
    output int                                 points_pending
);

    // Camera X/Y magnitude clamp, Q23.16
    localparam longint CAMERA_LIMIT = (longint'(1) <<< dpw_pkg::CAM_MAG_W) - 1;

    typedef struct packed {
        logic signed [dpw_pkg::WORLD_W-1:0] world_x;
        logic signed [dpw_pkg::WORLD_W-1:0] world_y;
        logic signed [dpw_pkg::WORLD_W-1:0] world_z;
        logic [dpw_pkg::COLOR_W-1:0]        red;
        logic [dpw_pkg::COLOR_W-1:0]        green;
        logic [dpw_pkg::COLOR_W-1:0]        blue;
    } world_point_t;

    // Shadow copy of the camera registers
    logic [dpw_pkg::PP_W-1:0]       principal_reg;
    logic [dpw_pkg::INVF_REG_W-1:0] inv_focal_reg;
    logic [dpw_pkg::DU_W-1:0]       depth_unit_reg;
    logic [dpw_pkg::ROT_ROW_W-1:0]  rot_row0_reg;
    logic [dpw_pkg::ROT_ROW_W-1:0]  rot_row1_reg;
    logic [dpw_pkg::ROT_ROW_W-1:0]  rot_row2_reg;
    logic [dpw_pkg::TR_REG_W-1:0]   translation_reg;

    world_point_t expected_points[$];
    int           fail_total = 0;

    // offset (Q.4) * 1/f (Q0.24) * depth (Q.24), magnitude rounded half up to Q.16
    function automatic longint lateral_q16(input longint offset,
                                           input logic [dpw_pkg::INVF_W-1:0] inv_f,
                                           input logic [dpw_pkg::Z24_W-1:0] z_q24);
        logic [16:0]  mag;
        logic [127:0] prod;
        logic [127:0] quot;
        mag  = (offset < 0) ? 17'(-offset) : 17'(offset);
        prod = 128'(mag) * 128'(inv_f) * 128'(z_q24);
        quot = (prod + (128'd1 << 35)) >> 36;
        if (quot > 128'(CAMERA_LIMIT))
            quot = 128'(CAMERA_LIMIT);
        return (offset < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
    endfunction

    // One row of R * cam + t, Q.32 sum rounded (ties up) to Q16.16, saturated
    function automatic logic signed [dpw_pkg::WORLD_W-1:0] rotate_axis(
            input logic [dpw_pkg::ROT_ROW_W-1:0] row_bits,
            input logic [dpw_pkg::TR_W-1:0]      shift_bits,
            input longint cam_x, input longint cam_y, input longint cam_z);
        longint acc;
        longint quot;
        longint r_x;
        longint r_y;
        longint r_z;
        r_x  = longint'($signed(row_bits[17:0]));
        r_y  = longint'($signed(row_bits[35:18]));
        r_z  = longint'($signed(row_bits[53:36]));
        acc  = longint'($signed(shift_bits)) <<< 20;
        acc  = acc + r_x * cam_x + r_y * cam_y + r_z * cam_z;
        quot = (acc + 32768) >>> 16;
        if (quot > longint'(dpw_pkg::WORLD_MAX))
            return dpw_pkg::WORLD_MAX;
        if (quot < longint'(dpw_pkg::WORLD_MIN))
            return dpw_pkg::WORLD_MIN;
        return quot[31:0];
    endfunction

    // Back-project one pixel; returns 0 when the pixel yields no point
    function automatic bit project_pixel(input logic [dpw_pkg::COORD_W-1:0] col,
                                         input logic [dpw_pkg::COORD_W-1:0] row,
                                         input logic [dpw_pkg::DEPTH_W-1:0] depth,
                                         input logic [dpw_pkg::COLOR_W-1:0] red,
                                         input logic [dpw_pkg::COLOR_W-1:0] green,
                                         input logic [dpw_pkg::COLOR_W-1:0] blue,
                                         output world_point_t point);
        logic [dpw_pkg::Z24_W-1:0] z_q24;
        logic [dpw_pkg::Z24_W:0]   z_biased;
        longint off_u;
        longint off_v;
        longint cam_x;
        longint cam_y;
        longint cam_z;
        point = '0;
        if (depth == 0 || col >= dpw_pkg::MAX_COLUMNS || row >= dpw_pkg::MAX_ROWS)
            return 1'b0;
        z_q24    = dpw_pkg::Z24_W'(depth) * dpw_pkg::Z24_W'(depth_unit_reg);
        off_u    = longint'({col, 4'b0000}) - longint'(principal_reg[15:0]);
        off_v    = longint'({row, 4'b0000}) - longint'(principal_reg[31:16]);
        cam_x    = lateral_q16(off_u, inv_focal_reg[23:0], z_q24);
        cam_y    = lateral_q16(off_v, inv_focal_reg[47:24], z_q24);
        z_biased = {1'b0, z_q24} + 41'd128;
        cam_z    = longint'(z_biased >> 8);
        point.world_x = rotate_axis(rot_row0_reg, translation_reg[20:0], cam_x, cam_y, cam_z);
        point.world_y = rotate_axis(rot_row1_reg, translation_reg[41:21], cam_x, cam_y, cam_z);
        point.world_z = rotate_axis(rot_row2_reg, translation_reg[62:42], cam_x, cam_y, cam_z);
        point.red     = red;
        point.green   = green;
        point.blue    = blue;
        return 1'b1;
    endfunction

    task automatic check_field(input string field_name, input longint want,
                               input longint seen);
        if (want != seen) begin
            $display("%0t: %s expected %0d, got %0d", $time, field_name, want, seen);
            fail_total++;
        end
    endtask

    // Watch all three channels at the rising edge
    always @(posedge aclk) begin
        world_point_t seen;
        world_point_t want;
        world_point_t predicted;
        if (!aresetn) begin
            principal_reg   = dpw_pkg::PP_RESET;
            inv_focal_reg   = dpw_pkg::INVF_RESET;
            depth_unit_reg  = dpw_pkg::DU_RESET;
            rot_row0_reg    = dpw_pkg::ROT0_RESET;
            rot_row1_reg    = dpw_pkg::ROT1_RESET;
            rot_row2_reg    = dpw_pkg::ROT2_RESET;
            translation_reg = dpw_pkg::TR_RESET;
            expected_points.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                seen = '{m_world_x, m_world_y, m_world_z, m_red_out, m_green_out, m_blue_out};
                if (expected_points.size() == 0) begin
                    $display("%0t: world point expected none, got x=%0d y=%0d z=%0d",
                             $time, m_world_x, m_world_y, m_world_z);
                    fail_total++;
                end else begin
                    want = expected_points.pop_front();
                    check_field("world_x", want.world_x, seen.world_x);
                    check_field("world_y", want.world_y, seen.world_y);
                    check_field("world_z", want.world_z, seen.world_z);
                    check_field("red_out", want.red, seen.red);
                    check_field("green_out", want.green, seen.green);
                    check_field("blue_out", want.blue, seen.blue);
                end
            end
            // register write, masked to the register width
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dpw_pkg::REG_PRINCIPAL:   principal_reg   = cfg_data[dpw_pkg::PP_W-1:0];
                    dpw_pkg::REG_INV_FOCAL:   inv_focal_reg   = cfg_data[dpw_pkg::INVF_REG_W-1:0];
                    dpw_pkg::REG_DEPTH_UNIT:  depth_unit_reg  = cfg_data[dpw_pkg::DU_W-1:0];
                    dpw_pkg::REG_ROT_ROW0:    rot_row0_reg    = cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                    dpw_pkg::REG_ROT_ROW1:    rot_row1_reg    = cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                    dpw_pkg::REG_ROT_ROW2:    rot_row2_reg    = cfg_data[dpw_pkg::ROT_ROW_W-1:0];
                    dpw_pkg::REG_TRANSLATION: translation_reg = cfg_data[dpw_pkg::TR_REG_W-1:0];
                    default: ;
                endcase
            end
            // pixel beat
            if (s_valid && s_ready) begin
                if (project_pixel(s_column, s_row_index, s_raw_depth, s_red_in, s_green_in,
                                  s_blue_in, predicted))
                    expected_points.insert(expected_points.size(), predicted);
            end
        end
        mismatch_count <= fail_total;
        points_pending <= expected_points.size();
    end

endmodule

### bench/tb_depth_pixel_to_world_point.sv
`timescale 1ns / 1ps

module tb_depth_pixel_to_world_point;

    localparam int CLOCK_LIMIT          = 400000;
    localparam int IDLE_PERCENT         = 37;
    localparam int PIPE_DRAIN_CYCLES    = 20;
    localparam int RECEIVER_HOLD_CYCLES = 80;
    localparam int RANDOM_PHASES        = 6;
    localparam int PHASE_PIXELS         = 335;
    localparam int PRESSURE_PIXELS      = 60;

    localparam logic [dpw_pkg::CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 3'd7;

    // Extreme rotation and translation fields
    localparam logic [dpw_pkg::ROT_W-1:0] ROT_ENTRY_MAX = 18'h1FFFF;
    localparam logic [dpw_pkg::ROT_W-1:0] ROT_ENTRY_MIN = 18'h20000;
    localparam logic [dpw_pkg::TR_W-1:0]  SHIFT_MAX     = 21'h0FFFFF;
    localparam logic [dpw_pkg::TR_W-1:0]  SHIFT_MIN     = 21'h100000;
    localparam logic [63:0]               ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic {SINK_RANDOM, SINK_STEADY} sink_mode_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [dpw_pkg::COORD_W-1:0]        s_column;
    logic [dpw_pkg::COORD_W-1:0]        s_row_index;
    logic [dpw_pkg::DEPTH_W-1:0]        s_raw_depth;
    logic [dpw_pkg::COLOR_W-1:0]        s_blue_in;
    logic [dpw_pkg::COLOR_W-1:0]        s_green_in;
    logic [dpw_pkg::COLOR_W-1:0]        s_red_in;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [dpw_pkg::WORLD_W-1:0] m_world_x;
    logic signed [dpw_pkg::WORLD_W-1:0] m_world_y;
    logic signed [dpw_pkg::WORLD_W-1:0] m_world_z;
    logic [dpw_pkg::COLOR_W-1:0]        m_red_out;
    logic [dpw_pkg::COLOR_W-1:0]        m_green_out;
    logic [dpw_pkg::COLOR_W-1:0]        m_blue_out;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [dpw_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [dpw_pkg::CFG_DATA_W-1:0]     cfg_data;
    int                                 mismatch_count;
    int                                 points_pending;

    sink_mode_t sink_mode;
    bit         sender_idles;
    bit         stall_request;
    int         cycle_count;

    depth_pixel_to_world_point u_dut (.*);

    depth_pixel_to_world_point_checker u_checker (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Cycle watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CLOCK_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_depth_pixel_to_world_point failed");
        $finish;
    end

    // Result receiver: random or steady ready, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (RECEIVER_HOLD_CYCLES) @(negedge aclk);
                stall_request = 1'b0;
            end
            if (sink_mode == SINK_STEADY)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offer one pixel beat, hold until taken, then maybe stay idle at random
    task automatic send_pixel(input logic [dpw_pkg::COORD_W-1:0] col,
                              input logic [dpw_pkg::COORD_W-1:0] row,
                              input logic [dpw_pkg::DEPTH_W-1:0] depth,
                              input logic [dpw_pkg::COLOR_W-1:0] blue,
                              input logic [dpw_pkg::COLOR_W-1:0] green,
                              input logic [dpw_pkg::COLOR_W-1:0] red);
        s_valid     <= 1'b1;
        s_column    <= col;
        s_row_index <= row;
        s_raw_depth <= depth;
        s_blue_in   <= blue;
        s_green_in  <= green;
        s_red_in    <= red;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (sender_idles) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
    endtask

    task automatic send_random_pixel(input bit with_depth);
        logic [dpw_pkg::DEPTH_W-1:0] depth;
        case ($urandom_range(9))
            0:       depth = with_depth ? 16'd1 : 16'd0;
            1, 2:    depth = 16'($urandom_range(255, 1));
            default: depth = 16'($urandom_range(65535, 1));
        endcase
        send_pixel(10'($urandom), 10'($urandom), depth, 8'($urandom), 8'($urandom),
                   8'($urandom));
    endtask

    // Stop offering and wait until every predicted point has come out
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (points_pending != 0) @(negedge aclk);
    endtask

    // Empty pipeline, including beats that give no point
    task automatic settle_pipeline();
        sink_mode = SINK_STEADY;
        wait_for_results();
        repeat (PIPE_DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [dpw_pkg::CFG_IDX_W-1:0] index,
                                  input logic [dpw_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Program the whole camera, then poke the unmapped index
    task automatic program_camera(input logic [63:0] principal, input logic [63:0] inv_focal,
                                  input logic [63:0] depth_unit, input logic [63:0] rot_row0,
                                  input logic [63:0] rot_row1, input logic [63:0] rot_row2,
                                  input logic [63:0] shift);
        write_register(dpw_pkg::REG_PRINCIPAL, principal);
        write_register(dpw_pkg::REG_INV_FOCAL, inv_focal);
        write_register(dpw_pkg::REG_DEPTH_UNIT, depth_unit);
        write_register(dpw_pkg::REG_ROT_ROW0, rot_row0);
        write_register(dpw_pkg::REG_ROT_ROW1, rot_row1);
        write_register(dpw_pkg::REG_ROT_ROW2, rot_row2);
        write_register(dpw_pkg::REG_TRANSLATION, shift);
        write_register(CFG_INDEX_UNUSED, {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Either a plausible camera and pose, or raw random register words
    task automatic program_random_camera(input bit plausible);
        logic [63:0] rows [3];
        int          k;
        if (plausible) begin
            for (k = 0; k < 3; k++) begin
                rows[k] = {10'd0, 18'($urandom_range(131072) - 65536),
                           18'($urandom_range(131072) - 65536),
                           18'($urandom_range(131072) - 65536)};
            end
            program_camera({32'd0, 16'($urandom_range(16383)), 16'($urandom_range(16383))},
                           {16'd0, 24'($urandom_range(200000, 10000)),
                            24'($urandom_range(200000, 10000))},
                           64'($urandom_range(70000, 1)), rows[0], rows[1], rows[2],
                           {1'b0, 21'($urandom), 21'($urandom), 21'($urandom)});
        end else begin
            program_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
        end
    endtask

    // Stimulus and verdict
    initial begin
        int phase;
        int n;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_column      = '0;
        s_row_index   = '0;
        s_raw_depth   = '0;
        s_blue_in     = '0;
        s_green_in    = '0;
        s_red_in      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sink_mode     = SINK_RANDOM;
        sender_idles  = 1'b1;
        stall_request = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset camera: corners, zero depth, near the principal point
        send_pixel(10'd0, 10'd0, 16'd0, 8'h00, 8'h00, 8'h00);
        send_pixel(10'd0, 10'd0, 16'd1, 8'h00, 8'h00, 8'h00);
        send_pixel(10'd1023, 10'd1023, 16'd65535, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(10'd0, 10'd1023, 16'd65535, 8'hAA, 8'h55, 8'hAA);
        send_pixel(10'd1023, 10'd0, 16'd1, 8'h55, 8'hAA, 8'h55);
        send_pixel(10'd325, 10'd253, 16'd1000, 8'h12, 8'h34, 8'h56);
        send_pixel(10'd326, 10'd254, 16'd1000, 8'h9A, 8'hBC, 8'hDE);
        send_pixel(10'd512, 10'd512, 16'd0, 8'hFF, 8'hFF, 8'hFF);

        // all-ones registers, extreme pose: camera and world saturation
        settle_pipeline();
        program_camera(ALL_ONES, ALL_ONES, ALL_ONES,
                       {10'h3FF, ROT_ENTRY_MAX, ROT_ENTRY_MIN, ROT_ENTRY_MAX},
                       {10'h000, ROT_ENTRY_MIN, ROT_ENTRY_MAX, ROT_ENTRY_MIN}, ALL_ONES,
                       {1'b1, SHIFT_MAX, SHIFT_MIN, SHIFT_MAX});
        sink_mode = SINK_RANDOM;
        send_pixel(10'd0, 10'd0, 16'd65535, 8'h01, 8'h02, 8'h03);
        send_pixel(10'd1023, 10'd1023, 16'd65535, 8'h80, 8'h40, 8'h20);
        send_pixel(10'd1023, 10'd0, 16'd1, 8'h10, 8'h08, 8'h04);
        send_pixel(10'd0, 10'd1023, 16'd1, 8'h7F, 8'hFE, 8'hEF);
        send_pixel(10'd0, 10'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);

        // all-zero camera: the point is the translation alone
        settle_pipeline();
        program_camera(64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
                       {1'b0, SHIFT_MIN, SHIFT_MAX, SHIFT_MIN});
        sink_mode = SINK_RANDOM;
        send_pixel(10'd0, 10'd0, 16'd65535, 8'h11, 8'h22, 8'h33);
        send_pixel(10'd1023, 10'd1023, 16'd1, 8'h44, 8'h55, 8'h66);
        send_pixel(10'd511, 10'd511, 16'd0, 8'h77, 8'h88, 8'h99);
        send_pixel(10'd1, 10'd2, 16'd3, 8'hCC, 8'hDD, 8'hEE);

        // principal point at the origin, identity pose: positive camera clamp
        settle_pipeline();
        program_camera(64'd0, ALL_ONES, ALL_ONES, 64'(dpw_pkg::ROT0_RESET),
                       64'(dpw_pkg::ROT1_RESET), 64'(dpw_pkg::ROT2_RESET), 64'd0);
        sink_mode = SINK_RANDOM;
        send_pixel(10'd1023, 10'd1023, 16'd65535, 8'h5A, 8'hA5, 8'h3C);
        send_pixel(10'd0, 10'd0, 16'd65535, 8'hC3, 8'h0F, 8'hF0);
        send_pixel(10'd1023, 10'd0, 16'd65535, 8'h69, 8'h96, 8'h81);

        // random phases, each with its own camera
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_pipeline();
            program_random_camera(phase % 2 == 0);
            sender_idles = (phase != 1);
            sink_mode    = (phase == 1) ? SINK_STEADY : SINK_RANDOM;
            for (n = 0; n < PHASE_PIXELS; n++) begin
                if (phase == 2 && n == PHASE_PIXELS / 2) begin
                    stall_request = 1'b1;
                    sender_idles  = 1'b0;
                end
                if (phase == 2 && n == PHASE_PIXELS / 2 + PRESSURE_PIXELS)
                    sender_idles = 1'b1;
                if (phase == 3 && n == PHASE_PIXELS / 2) begin
                    wait_for_results();
                    @(negedge aclk);
                end
                send_random_pixel(phase == 2 && n >= PHASE_PIXELS / 2 &&
                                  n < PHASE_PIXELS / 2 + PRESSURE_PIXELS);
            end
        end

        settle_pipeline();
        if (mismatch_count == 0 && points_pending == 0) begin
            $display("tb_depth_pixel_to_world_point passed");
        end else begin
            $display("tb_depth_pixel_to_world_point failed");
        end
        $finish;
    end

endmodule
